### rtl/dat_pkg.sv
// Shared types and constants for the double-array trie lookup.
`default_nettype none

package dat_pkg;

  // Field widths of one input item.
  localparam int OP_W    = 2;
  localparam int SYM_W   = 5;
  localparam int INDEX_W = 10;
  localparam int BASE_W  = 10;
  localparam int CHECK_W = 11;

  // Default table size and the fixed alphabet.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam logic [SYM_W-1:0] ALPHABET_SIZE = 5'd26;
  localparam int ROOT_NODE = 1;

  // Operation codes carried in tuser.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  // One node of the table: check in the upper bits, base in the lower bits.
  typedef struct packed {
    logic signed [CHECK_W-1:0] check;
    logic [BASE_W-1:0]         base;
  } entry_t;

endpackage

`default_nettype wire

### rtl/dat_node_mem.sv
// Node table: one write port and one read port, read data registered.
`default_nettype none

module dat_node_mem #(
  parameter int DEPTH  = dat_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire dat_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output dat_pkg::entry_t      rd_data
);

  dat_pkg::entry_t mem [DEPTH];
  dat_pkg::entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/double_array_trie_lookup.sv
// A symbol walks in two dependent reads of the node table on its single read port: the base of
// the cursor, then the child entry (no read if the word already missed or the letter is outside
// the alphabet). in_tready is low while the base is read, so a new item waits for that read; an
// end-of-word query reads the cursor entry and registers its result once the output is free.
// After reset the table is cleared one entry a cycle, with in_tready low.
`default_nettype none

module double_array_trie_lookup #(
  parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: symbol[4:0], entry_index[14:5], entry_base[24:15], entry_check[35:25]
  input  wire logic [39:0] in_tdata,
  // in_tuser: opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: found[0], out_of_range[1]
  output logic [7:0]       out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (IDX_W + 1 > dat_pkg::CHECK_W) ? IDX_W + 1 : dat_pkg::CHECK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] ROOT     = IDX_W'(dat_pkg::ROOT_NODE);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_BASE  = 5'b00100,
    ST_CHILD = 5'b01000,
    ST_END   = 5'b10000
  } state_t;

  // Input fields.
  logic [dat_pkg::OP_W-1:0]           in_op;
  logic [dat_pkg::SYM_W-1:0]          in_symbol;
  logic [dat_pkg::INDEX_W-1:0]        in_index;
  logic [dat_pkg::BASE_W-1:0]         in_base;
  logic signed [dat_pkg::CHECK_W-1:0] in_check;

  assign in_op     = in_tuser[1:0];
  assign in_symbol = in_tdata[4:0];
  assign in_index  = in_tdata[14:5];
  assign in_base   = in_tdata[24:15];
  assign in_check  = in_tdata[35:25];

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          cursor_r, cursor_nxt;
  logic                      miss_r, miss_nxt;
  logic                      range_r, range_nxt;
  logic [dat_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic [IDX_W-1:0]          q_r, q_nxt;
  logic [IDX_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic                      out_oor_r, out_oor_nxt;

  // Memory interface.
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  dat_pkg::entry_t  mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  dat_pkg::entry_t  mem_rd_data;

  // Walk arithmetic.
  logic [CMP_W-1:0]             child_ext;
  logic                         child_oor;
  logic [dat_pkg::CHECK_W-1:0]  check_mag;
  logic                         child_fail;
  logic [IDX_W-1:0]             cursor_eff;
  logic                         miss_eff;
  logic                         in_xfer;
  logic                         out_free;
  logic                         write_ok;

  dat_node_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_CHILD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign write_ok  = CMP_W'(in_index) < DEPTH_C;

  // Child index from the base of the cursor and the stored letter.
  assign child_ext = CMP_W'(mem_rd_data.base) + CMP_W'(sym_r);
  assign child_oor = child_ext >= DEPTH_C;

  // The child belongs to the cursor only if the magnitude of its check matches.
  assign check_mag  = mem_rd_data.check[dat_pkg::CHECK_W-1]
                    ? (~mem_rd_data.check + 1'b1) : mem_rd_data.check;
  assign child_fail = CMP_W'(check_mag) != CMP_W'(cursor_r);

  // Walk state as resolved by a child read finishing this cycle.
  always_comb begin
    cursor_eff = cursor_r;
    miss_eff   = miss_r;
    if (state_r == ST_CHILD) begin
      if (child_fail) begin
        miss_eff = 1'b1;
      end else begin
        cursor_eff = q_r;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    miss_nxt      = miss_r;
    range_nxt     = range_r;
    sym_nxt       = sym_r;
    q_nxt         = q_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_oor_nxt   = out_oor_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ST_BASE: begin
        if (child_oor) begin
          miss_nxt  = 1'b1;
          range_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          q_nxt       = child_ext[IDX_W-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = child_ext[IDX_W-1:0];
          state_nxt   = ST_CHILD;
        end
      end

      ST_IDLE, ST_CHILD: begin
        cursor_nxt = cursor_eff;
        miss_nxt   = miss_eff;
        state_nxt  = ST_IDLE;
        if (in_xfer) begin
          unique case (in_op)
            dat_pkg::OP_WRITE: begin
              mem_wr_en         = write_ok;
              mem_wr_addr       = IDX_W'(in_index);
              mem_wr_data.base  = in_base;
              mem_wr_data.check = in_check;
            end
            dat_pkg::OP_STEP: begin
              if (!miss_eff) begin
                if (in_symbol >= dat_pkg::ALPHABET_SIZE) begin
                  miss_nxt = 1'b1;
                end else begin
                  sym_nxt     = in_symbol;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = cursor_eff;
                  state_nxt   = ST_BASE;
                end
              end
            end
            dat_pkg::OP_END: begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = cursor_eff;
              state_nxt   = ST_END;
            end
            default: begin
              // Unused opcode: the transfer is dropped.
            end
          endcase
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = !miss_r && mem_rd_data.check[dat_pkg::CHECK_W-1];
          out_oor_nxt   = range_r;
          cursor_nxt    = ROOT;
          miss_nxt      = 1'b0;
          range_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= ROOT;
      miss_r      <= 1'b0;
      range_r     <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      miss_r      <= miss_nxt;
      range_r     <= range_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    q_r         <= q_nxt;
    out_found_r <= out_found_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_oor_r, out_found_r};

endmodule

`default_nettype wire

### tb/tb_double_array_trie_lookup.sv
// Self-checking testbench for the double-array trie lookup: directed and random trie walks.
`default_nettype none

module tb_double_array_trie_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = dat_pkg::TABLE_DEPTH_DEF;
  localparam logic [dat_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_WORD = 6;
  // Covers the table clearing pass after reset with a wide margin.
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic found;
    logic out_of_range;
  } lookup_result_t;

  typedef struct packed {
    logic [3:0]                                 len;
    logic [MAX_WORD-1:0][dat_pkg::SYM_W-1:0]    sym;
  } word_t;

  // Tracks the trie walk and holds the query answers still to come out.
  class trie_scoreboard;
    logic [dat_pkg::BASE_W-1:0]         node_base [DEPTH];
    logic signed [dat_pkg::CHECK_W-1:0] node_check [DEPTH];
    int                                 cursor;
    bit                                 missed;
    bit                                 ranged;
    lookup_result_t                     answers [$];
    int                                 errors;

    function new();
      foreach (node_base[i]) begin
        node_base[i]  = '0;
        node_check[i] = '0;
      end
      cursor = dat_pkg::ROOT_NODE;
      missed = 1'b0;
      ranged = 1'b0;
      errors = 0;
    endfunction

    // Move the cursor by one letter, or record a miss.
    function void walk(logic [dat_pkg::SYM_W-1:0] sym);
      int child;
      int parent;
      if (missed) return;
      if (sym >= dat_pkg::ALPHABET_SIZE) begin
        missed = 1'b1;
        return;
      end
      child = int'(node_base[cursor]) + int'(sym);
      if (child >= DEPTH) begin
        missed = 1'b1;
        ranged = 1'b1;
        return;
      end
      parent = int'(node_check[child]);
      if (parent < 0) parent = -parent;
      if (parent != cursor) begin
        missed = 1'b1;
        return;
      end
      cursor = child;
    endfunction

    // Apply one accepted input transfer.
    function void note_transfer(logic [dat_pkg::OP_W-1:0] op,
                                logic [dat_pkg::SYM_W-1:0] sym,
                                logic [dat_pkg::INDEX_W-1:0] idx,
                                logic [dat_pkg::BASE_W-1:0] base,
                                logic signed [dat_pkg::CHECK_W-1:0] check);
      lookup_result_t answer;
      case (op)
        dat_pkg::OP_WRITE: begin
          if (int'(idx) < DEPTH) begin
            node_base[idx]  = base;
            node_check[idx] = check;
          end
        end
        dat_pkg::OP_STEP: walk(sym);
        dat_pkg::OP_END: begin
          answer.found        = !missed && (node_check[cursor] < 0);
          answer.out_of_range = ranged;
          answers.push_back(answer);
          cursor = dat_pkg::ROOT_NODE;
          missed = 1'b0;
          ranged = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result transfer with the oldest answer.
    function void check_result(logic [7:0] data);
      lookup_result_t want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b out_of_range=%0b",
                 $time, data[0], data[1]);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (data[0] !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, data[0]);
        errors++;
      end
      if (data[1] !== want.out_of_range) begin
        $display("%0t: out_of_range mismatch, expected %0b, actual %0b",
                 $time, want.out_of_range, data[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tvalid;
  logic        out_tready;

  trie_scoreboard sb;

  // Stimulus-side copy of the table, used to build words that really walk.
  logic [dat_pkg::BASE_W-1:0]         shadow_base [DEPTH];
  logic signed [dat_pkg::CHECK_W-1:0] shadow_check [DEPTH];
  word_t                              stored_words [$];
  int                                 in_max_gap;
  int                                 out_max_stall;
  int                                 sent;
  int                                 idle_cycles;

  double_array_trie_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive one input transfer after a random gap and wait for it to be taken.
  task automatic send_item(logic [dat_pkg::OP_W-1:0] op, logic [dat_pkg::SYM_W-1:0] sym,
                           logic [dat_pkg::INDEX_W-1:0] idx,
                           logic [dat_pkg::BASE_W-1:0] base,
                           logic signed [dat_pkg::CHECK_W-1:0] check);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {4'd0, check, base, idx, sym};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(op, sym, idx, base, check);
    if (op == dat_pkg::OP_WRITE) begin
      shadow_base[idx]  = base;
      shadow_check[idx] = check;
    end
    if (op != OP_UNUSED) sent++;
    @(negedge clk);
  endtask

  task automatic write_entry(int idx, int base, int check);
    send_item(dat_pkg::OP_WRITE, dat_pkg::SYM_W'($urandom), dat_pkg::INDEX_W'(idx),
              dat_pkg::BASE_W'(base), dat_pkg::CHECK_W'(check));
  endtask

  task automatic step_letter(int sym);
    send_item(dat_pkg::OP_STEP, dat_pkg::SYM_W'(sym), dat_pkg::INDEX_W'($urandom),
              dat_pkg::BASE_W'($urandom), dat_pkg::CHECK_W'($urandom));
  endtask

  task automatic end_word();
    send_item(dat_pkg::OP_END, dat_pkg::SYM_W'($urandom), dat_pkg::INDEX_W'($urandom),
              dat_pkg::BASE_W'($urandom), dat_pkg::CHECK_W'($urandom));
  endtask

  // Random word; a small alphabet half the time so that prefixes get shared.
  function automatic word_t make_word(bit odd_letters);
    word_t w;
    w.len = 4'($urandom_range(0, MAX_WORD));
    for (int i = 0; i < MAX_WORD; i++) begin
      if (odd_letters && $urandom_range(0, 3) == 0)
        w.sym[i] = dat_pkg::SYM_W'($urandom_range(26, 31));
      else if ($urandom_range(0, 1) == 0)
        w.sym[i] = dat_pkg::SYM_W'($urandom_range(0, 3));
      else
        w.sym[i] = dat_pkg::SYM_W'($urandom_range(0, 25));
    end
    return w;
  endfunction

  // Add a word: claim free slots along the path, then mark the last node as a word end.
  task automatic insert_word(word_t w);
    int node;
    int child;
    int mag;
    int new_base;
    bit ok;
    node = dat_pkg::ROOT_NODE;
    ok   = 1'b1;
    for (int i = 0; i < w.len && ok; i++) begin
      child = int'(shadow_base[node]) + int'(w.sym[i]);
      if (child >= DEPTH) begin
        ok = 1'b0;
      end else begin
        mag = int'(shadow_check[child]);
        if (mag < 0) mag = -mag;
        if (mag == node) begin
          node = child;
        end else if (shadow_check[child] == 0 && child != dat_pkg::ROOT_NODE) begin
          // Now and then a base near the top, so later letters run off the table.
          if ($urandom_range(0, 15) == 0) new_base = $urandom_range(1000, 1023);
          else new_base = $urandom_range(2, 990);
          write_entry(child, new_base, node);
          node = child;
        end else begin
          ok = 1'b0;
        end
      end
    end
    if (ok) begin
      mag = int'(shadow_check[node]);
      if (mag < 0) mag = -mag;
      if (node == dat_pkg::ROOT_NODE) mag = 1;
      write_entry(node, shadow_base[node], -mag);
      stored_words.push_back(w);
    end
  endtask

  // Walk a word and ask for it, sometimes with a table write in the middle.
  task automatic query_word(word_t w);
    for (int i = 0; i < w.len; i++) begin
      step_letter(w.sym[i]);
      if ($urandom_range(0, 11) == 0)
        write_entry($urandom_range(0, DEPTH - 1), $urandom, $urandom);
    end
    end_word();
  endtask

  // Result side: random stalls, some of them while a result is waiting.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (stall > 0) begin
        out_tready = 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus.
  initial begin
    word_t w;
    int    pick;
    int    first_random;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = dat_pkg::OP_WRITE;
    in_max_gap    = 3;
    out_max_stall = 3;
    sent          = 0;
    foreach (shadow_base[i]) begin
      shadow_base[i]  = '0;
      shadow_check[i] = '0;
    end
    sb = new();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Empty word on the cleared table, then an unused opcode.
    end_word();
    send_item(OP_UNUSED, dat_pkg::SYM_W'($urandom), dat_pkg::INDEX_W'($urandom),
              dat_pkg::BASE_W'($urandom), dat_pkg::CHECK_W'($urandom));
    // Root marked as a word end: the empty word is found.
    write_entry(dat_pkg::ROOT_NODE, 1023, -1);
    end_word();
    // Child past the end of the table, then a letter after the miss.
    step_letter(25);
    step_letter(0);
    end_word();
    // Letter outside the alphabet.
    step_letter(31);
    end_word();
    // One-letter word found.
    write_entry(dat_pkg::ROOT_NODE, 2, 0);
    write_entry(2, 0, -1);
    step_letter(0);
    end_word();
    // Write in the middle of a walk clears the word end it is about to report.
    step_letter(0);
    write_entry(2, 100, 1);
    end_word();
    // Field extremes, then a step onto an empty slot.
    write_entry(1023, 1023, 1023);
    write_entry(0, 0, -1024);
    step_letter(1);
    end_word();

    // Random part: mostly words built into the trie and asked for again.
    first_random = sent;
    while (sent < first_random + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        in_max_gap    = ($urandom_range(0, 2) == 0) ? 0 : 3;
        out_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 3;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        insert_word(make_word(1'b0));
      end else if (pick < 65 && stored_words.size() > 0) begin
        w = stored_words[$urandom_range(0, stored_words.size() - 1)];
        case ($urandom_range(0, 4))
          0: if (w.len > 0) w.len = 4'($urandom_range(0, w.len - 1));
          1: begin
            if (w.len < MAX_WORD) begin
              w.sym[w.len] = dat_pkg::SYM_W'($urandom_range(0, 25));
              w.len = w.len + 4'd1;
            end
          end
          default: ;
        endcase
        query_word(w);
      end else if (pick < 85) begin
        query_word(make_word(1'b1));
      end else begin
        send_item(dat_pkg::OP_W'($urandom_range(0, 3)), dat_pkg::SYM_W'($urandom),
                  dat_pkg::INDEX_W'($urandom), dat_pkg::BASE_W'($urandom),
                  dat_pkg::CHECK_W'($urandom));
      end
    end
    in_tvalid = 1'b0;

    // Drain, then leave room for any stray result.
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/dat_pkg.sv
rtl/dat_node_mem.sv
rtl/double_array_trie_lookup.sv
tb/tb_double_array_trie_lookup.sv
